[design/spf_pkg.sv]
`default_nettype none

package spf_pkg;

    localparam int MAX_VALUES  = 32;
    localparam int MAX_RESULTS = 31;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CNT_W       = $clog2(MAX_VALUES + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    typedef logic signed [DATA_W-1:0] data_t;

    // Per-cycle command broadcast to every cell of the sorting chain
    typedef struct packed {
        logic  insert;   // place value into the sorted row
        logic  shift;    // drop cell 0, everything moves one place down
        data_t value;
    } cell_ctl_t;

endpackage

`default_nettype wire

[design/spf_sample_if.sv]
`default_nettype none

interface spf_sample_if;
    logic          valid;
    logic          ready;
    spf_pkg::data_t value;
    logic          last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

[design/spf_result_if.sv]
`default_nettype none

interface spf_result_if;
    logic           valid;
    logic           ready;
    spf_pkg::data_t low_value;
    spf_pkg::data_t high_value;
    logic           pair_found;
    logic           overflow;
    logic           run_end;

    modport source (output valid, output low_value, output high_value, output pair_found,
                    output overflow, output run_end, input ready);
    modport sink   (input valid, input low_value, input high_value, input pair_found,
                    input overflow, input run_end, output ready);
endinterface

`default_nettype wire

[design/sorted_pair_sum_finder_top.sv]
// Channel   Dir  Fields
// sample    in   value[31:0] signed, last
// result    out  low_value[31:0], high_value[31:0], pair_found, overflow, run_end
// cfg       in   cfg_wr_en, cfg_wr_data[31:0] (target sum)
//
// A value that is not last is taken while idle: the cell row inserts it in sorted place.
// The last value starts the pointer scan: one step per cycle unless a match stalls,
// over n-1 steps for n held values, then the final result; sample.ready is low throughout.
// Each step reads the low end at cell 0 and the high end through one mux into the row.
// A full output register stalls a matching step only when an earlier pair is still held,
// and holds back the final result until it drains.
// Reset clears the count, the overflow flag and the target; cell contents are not reset.
`default_nettype none

module sorted_pair_sum_finder_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire spf_pkg::data_t      cfg_wr_data,
    spf_sample_if.sink               sample,
    spf_result_if.source             result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                      state_reg,  state_next;
    logic [spf_pkg::CNT_W-1:0] count_reg,  count_next;
    logic                      drop_reg,   drop_next;
    logic [spf_pkg::IDX_W-1:0] span_reg,   span_next;
    logic [spf_pkg::RES_W-1:0] emit_reg,   emit_next;
    logic                      pend_valid_reg, pend_valid_next;
    spf_pkg::data_t            pend_low_reg,   pend_low_next;
    spf_pkg::data_t            pend_high_reg,  pend_high_next;
    spf_pkg::data_t            target_reg;

    logic                      out_valid_reg, out_valid_next;
    spf_pkg::data_t            out_low_reg,   out_low_next;
    spf_pkg::data_t            out_high_reg,  out_high_next;
    logic                      out_found_reg, out_found_next;
    logic                      out_ovf_reg,   out_ovf_next;
    logic                      out_end_reg,   out_end_next;

    spf_pkg::cell_ctl_t        ctl;
    spf_pkg::data_t            low_v;
    spf_pkg::data_t            high_v;
    logic                      accept;
    logic                      room;
    logic [spf_pkg::CNT_W-1:0] count_after;
    logic signed [spf_pkg::DATA_W:0] pair_sum;
    logic signed [spf_pkg::DATA_W:0] target_ext;
    logic                      match;
    logic                      too_big;
    logic                      done;
    logic                      out_free;
    logic                      push;

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign room         = (count_reg < spf_pkg::CNT_W'(spf_pkg::MAX_VALUES));
    assign count_after  = room ? count_reg + spf_pkg::CNT_W'(1) : count_reg;

    // full-width sum, no wrap
    assign pair_sum   = $signed({low_v[spf_pkg::DATA_W-1], low_v})
                      + $signed({high_v[spf_pkg::DATA_W-1], high_v});
    assign target_ext = $signed({target_reg[spf_pkg::DATA_W-1], target_reg});
    assign match      = (pair_sum == target_ext);
    assign too_big    = (pair_sum > target_ext);
    assign done       = (span_reg == '0) || (emit_reg == spf_pkg::RES_W'(spf_pkg::MAX_RESULTS));
    assign out_free   = !out_valid_reg || result.ready;

    spf_chain u_chain (
        .clk        (clk),
        .ctl        (ctl),
        .count      (count_reg),
        .rd_idx     (span_reg),
        .low_value  (low_v),
        .high_value (high_v)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        drop_next       = drop_reg;
        span_next       = span_reg;
        emit_next       = emit_reg;
        pend_valid_next = pend_valid_reg;
        pend_low_next   = pend_low_reg;
        pend_high_next  = pend_high_reg;
        ctl.insert      = accept && room;
        ctl.shift       = 1'b0;
        ctl.value       = sample.value;
        push            = 1'b0;
        out_low_next    = out_low_reg;
        out_high_next   = out_high_reg;
        out_found_next  = out_found_reg;
        out_ovf_next    = out_ovf_reg;
        out_end_next    = out_end_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = count_after;
                    drop_next  = drop_reg || !room;
                    if (sample.last)
                    begin
                        state_next = ST_SCAN;
                        span_next  = spf_pkg::IDX_W'(count_after - spf_pkg::CNT_W'(1));
                        emit_next  = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!done)
                begin
                    // a match must first move the held pair out
                    if (!(match && pend_valid_reg && !out_free))
                    begin
                        span_next = span_reg - spf_pkg::IDX_W'(1);
                        if (match)
                        begin
                            if (pend_valid_reg)
                            begin
                                push           = 1'b1;
                                out_low_next   = pend_low_reg;
                                out_high_next  = pend_high_reg;
                                out_found_next = 1'b1;
                                out_ovf_next   = drop_reg;
                                out_end_next   = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_low_next   = low_v;
                            pend_high_next  = high_v;
                            emit_next       = emit_reg + spf_pkg::RES_W'(1);
                            ctl.shift       = 1'b1;
                        end
                        else if (!too_big)
                        begin
                            ctl.shift = 1'b1;
                        end
                    end
                end
                else if (out_free)
                begin
                    push            = 1'b1;
                    out_low_next    = pend_valid_reg ? pend_low_reg  : '0;
                    out_high_next   = pend_valid_reg ? pend_high_reg : '0;
                    out_found_next  = pend_valid_reg;
                    out_ovf_next    = drop_reg;
                    out_end_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    drop_next       = 1'b0;
                    emit_next       = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            drop_reg       <= 1'b0;
            span_reg       <= '0;
            emit_reg       <= '0;
            pend_valid_reg <= 1'b0;
            target_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            drop_reg       <= drop_next;
            span_reg       <= span_next;
            emit_reg       <= emit_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_low_reg  <= pend_low_next;
        pend_high_reg <= pend_high_next;
        out_low_reg   <= out_low_next;
        out_high_reg  <= out_high_next;
        out_found_reg <= out_found_next;
        out_ovf_reg   <= out_ovf_next;
        out_end_reg   <= out_end_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.low_value  = out_low_reg;
    assign result.high_value = out_high_reg;
    assign result.pair_found = out_found_reg;
    assign result.overflow   = out_ovf_reg;
    assign result.run_end    = out_end_reg;

    a_idle_no_held_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held pair left over after scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spf_pkg::CNT_W'(spf_pkg::MAX_VALUES))
        else $error("value count beyond capacity");

    a_no_match_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.pair_found) |-> result.run_end)
        else $error("no-match result not marked as run end");

    a_scan_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_SCAN && state_reg == ST_IDLE) |-> (out_valid_reg && out_end_reg))
        else $error("scan finished without final result");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg <= spf_pkg::RES_W'(spf_pkg::MAX_RESULTS))
        else $error("too many pairs emitted");

endmodule

`default_nettype wire

[design/spf_cell.sv]
`default_nettype none

module spf_cell (
    input  wire logic              clk,
    input  wire spf_pkg::cell_ctl_t ctl,
    input  wire logic              empty,
    input  wire spf_pkg::data_t    left_value,
    input  wire logic              left_gt,
    input  wire spf_pkg::data_t    right_value,
    output logic                   gt,
    output spf_pkg::data_t         value
);

    spf_pkg::data_t value_reg;
    spf_pkg::data_t value_next;

    // empty cells count as +infinity so the new value lands at the end of the row
    assign gt    = empty || (value_reg > ctl.value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.insert && gt)
        begin
            value_next = left_gt ? left_value : ctl.value;
        end
        else if (ctl.shift)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

[design/spf_chain.sv]
`default_nettype none

module spf_chain (
    input  wire logic                      clk,
    input  wire spf_pkg::cell_ctl_t        ctl,
    input  wire logic [spf_pkg::CNT_W-1:0] count,
    input  wire logic [spf_pkg::IDX_W-1:0] rd_idx,
    output spf_pkg::data_t                 low_value,
    output spf_pkg::data_t                 high_value
);

    spf_pkg::data_t cell_val [spf_pkg::MAX_VALUES];
    logic           cell_gt  [spf_pkg::MAX_VALUES];

    for (genvar i = 0; i < spf_pkg::MAX_VALUES; i++)
    begin : g_cell
        spf_pkg::data_t left_v;
        spf_pkg::data_t right_v;
        logic           left_g;
        logic           empty;

        assign empty = (spf_pkg::CNT_W'(i) >= count);

        if (i == 0)
        begin : g_first
            assign left_v = ctl.value;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_v = cell_val[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == spf_pkg::MAX_VALUES - 1)
        begin : g_end
            assign right_v = cell_val[i];
        end
        else
        begin : g_inner
            assign right_v = cell_val[i+1];
        end

        spf_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .empty       (empty),
            .left_value  (left_v),
            .left_gt     (left_g),
            .right_value (right_v),
            .gt          (cell_gt[i]),
            .value       (cell_val[i])
        );
    end

    assign low_value  = cell_val[0];
    assign high_value = cell_val[rd_idx];

endmodule

`default_nettype wire

[bench/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        spf_pkg::data_t low_v;
        spf_pkg::data_t high_v;
        logic           found;
        logic           ovf;
        logic           fin;
    } pair_res_t;

    typedef enum logic {ROW_SET_TARGET, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t      kind;
        spf_pkg::data_t val;
        logic           last;
        logic           typed;
        pair_res_t      res;
    } dir_row_t;

    localparam spf_pkg::data_t VAL_MIN = spf_pkg::data_t'(32'h8000_0000);
    localparam spf_pkg::data_t VAL_MAX = spf_pkg::data_t'(32'h7FFF_FFFF);
    localparam int    TOTAL_ITEMS   = 310;
    localparam int    SETTLE_CYCLES = 4;
    localparam int    DRAIN_CYCLES  = 40;
    localparam int    MAX_PRINTS    = 50;

    logic           clk;
    logic           rst_n;
    logic           cfg_wr_en;
    spf_pkg::data_t cfg_wr_data;

    spf_sample_if sample_ch();
    spf_result_if result_ch();

    sorted_pair_sum_finder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample_ch),
        .result      (result_ch)
    );

    // predictor state
    spf_pkg::data_t target_reg = '0;
    spf_pkg::data_t held_vals[$];
    logic           held_drop = 1'b0;
    pair_res_t      fresh_pairs[$];
    pair_res_t      pending_pairs[$];

    dir_row_t  dir_rows[$];

    int next_gap      = 0;
    bit sample_up     = 1'b0;
    bit send_calm     = 1'b0;
    bit recv_calm     = 1'b0;
    int bad_count     = 0;
    int sample_count  = 0;
    int set_count     = 0;
    int pair_count    = 0;
    int overflow_sets = 0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        bad_count++;
        if (bad_count <= MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Collects the value; on the closing value sorts the set and walks it from both ends.
    function automatic void predict_pairs(input spf_pkg::data_t v, input logic l);
        spf_pkg::data_t srt [spf_pkg::MAX_VALUES];
        spf_pkg::data_t key;
        int             n;
        int             lo;
        int             hi;
        int             b;
        longint         s;
        pair_res_t      r;
        fresh_pairs.delete();
        if (held_vals.size() < spf_pkg::MAX_VALUES)
            held_vals = {held_vals, v};
        else
            held_drop = 1'b1;
        if (!l)
            return;
        n = held_vals.size();
        for (int a = 0; a < n; a++)
        begin
            key = held_vals[a];
            b   = a;
            while (b > 0 && srt[b-1] > key)
            begin
                srt[b] = srt[b-1];
                b--;
            end
            srt[b] = key;
        end
        lo = 0;
        hi = n - 1;
        // full-width sum, no wrap
        while (lo < hi && fresh_pairs.size() < spf_pkg::MAX_RESULTS)
        begin
            s = longint'(srt[lo]) + longint'(srt[hi]);
            if (s == longint'(target_reg))
            begin
                r = '{srt[lo], srt[hi], 1'b1, held_drop, 1'b0};
                fresh_pairs = {fresh_pairs, r};
                lo++;
            end
            else if (s > longint'(target_reg))
                hi--;
            else
                lo++;
        end
        if (fresh_pairs.size() == 0)
        begin
            r = '{spf_pkg::data_t'(0), spf_pkg::data_t'(0), 1'b0, held_drop, 1'b1};
            fresh_pairs = {fresh_pairs, r};
        end
        else
            fresh_pairs[fresh_pairs.size()-1].fin = 1'b1;
        held_vals.delete();
        held_drop = 1'b0;
    endfunction

    function automatic void add_row(input row_kind_t kind, input spf_pkg::data_t v,
                                    input logic l, input logic typed,
                                    input spf_pkg::data_t lo_v, input spf_pkg::data_t hi_v,
                                    input logic found);
        dir_row_t row;
        row.kind  = kind;
        row.val   = v;
        row.last  = l;
        row.typed = typed;
        row.res   = '{lo_v, hi_v, found, 1'b0, 1'b1};
        dir_rows  = {dir_rows, row};
    endfunction

    task automatic send_sample(input spf_pkg::data_t v, input logic l, input logic typed,
                               input pair_res_t typed_res);
        if (next_gap > 0)
            repeat (next_gap) @(posedge clk);
        sample_ch.valid <= 1'b1;
        sample_ch.value <= v;
        sample_ch.last  <= l;
        sample_up = 1'b1;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        predict_pairs(v, l);
        sample_count++;
        if (l)
        begin
            set_count++;
            if (fresh_pairs[0].ovf)
                overflow_sets++;
            if (typed)
                pending_pairs = {pending_pairs, typed_res};
            else
                foreach (fresh_pairs[i])
                    pending_pairs = {pending_pairs, fresh_pairs[i]};
        end
        // keep valid up across back-to-back transfers
        next_gap = send_calm ? 0 : $urandom_range(0, 14);
        if (next_gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            sample_up = 1'b0;
        end
    endtask

    task automatic write_target(input spf_pkg::data_t t);
        if (sample_up)
        begin
            sample_ch.valid <= 1'b0;
            sample_up = 1'b0;
        end
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= t;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        target_reg = t;
    endtask

    // stimulus
    initial begin
        int             set_len;
        int             pick;
        spf_pkg::data_t v;
        spf_pkg::data_t prev_v;
        spf_pkg::data_t t;
        longint         cand;

        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.value <= '0;
        sample_ch.last  <= 1'b0;

        // single value straight after reset, target still zero
        add_row(ROW_SAMPLE, 32'sd5, 1'b1, 1'b1, '0, '0, 1'b0);
        // extremes miss a zero target
        add_row(ROW_SAMPLE, VAL_MAX, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, VAL_MIN, 1'b1, 1'b1, '0, '0, 1'b0);
        add_row(ROW_SET_TARGET, -32'sd1, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, VAL_MIN, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, VAL_MAX, 1'b1, 1'b1, VAL_MIN, VAL_MAX, 1'b1);
        // max + max only hits -2 if the sum wraps
        add_row(ROW_SET_TARGET, -32'sd2, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, VAL_MAX, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, VAL_MAX, 1'b1, 1'b1, '0, '0, 1'b0);
        // likewise min + min against zero
        add_row(ROW_SET_TARGET, 32'sd0, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, VAL_MIN, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, VAL_MIN, 1'b1, 1'b1, '0, '0, 1'b0);
        // duplicates, several matches
        add_row(ROW_SET_TARGET, 32'sd10, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, 32'sd7, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, 32'sd3, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, 32'sd5, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, 32'sd5, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, 32'sd3, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, 32'sd7, 1'b1, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SET_TARGET, VAL_MAX, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, VAL_MAX, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, 32'sd0, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, -32'sd1, 1'b1, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SET_TARGET, VAL_MIN, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, VAL_MIN, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(ROW_SAMPLE, 32'sd0, 1'b1, 1'b1, VAL_MIN, 32'sd0, 1'b1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_SET_TARGET)
                write_target(dir_rows[i].val);
            else
                send_sample(dir_rows[i].val, dir_rows[i].last, dir_rows[i].typed,
                            dir_rows[i].res);
        end

        while (sample_count < TOTAL_ITEMS)
        begin
            send_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       t = VAL_MIN;
                    1:       t = VAL_MAX;
                    2:       t = '0;
                    3:       t = -32'sd1;
                    4:       t = spf_pkg::data_t'($urandom_range(0, 200)) - 32'sd100;
                    default: t = spf_pkg::data_t'($urandom());
                endcase
                write_target(t);
            end
            pick = $urandom_range(0, 99);
            if (pick < 78)
                set_len = $urandom_range(1, 10);
            else if (pick < 92)
                set_len = $urandom_range(11, spf_pkg::MAX_VALUES);
            else
                set_len = $urandom_range(spf_pkg::MAX_VALUES + 1, spf_pkg::MAX_VALUES + 8);
            prev_v = spf_pkg::data_t'($urandom());
            for (int j = 0; j < set_len; j++)
            begin
                // bias towards partners of earlier values so pairs actually turn up
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: cand = longint'(target_reg) - longint'(prev_v);
                    4, 5, 6:    cand = (longint'(target_reg) >>> 1)
                                       + longint'($urandom_range(0, 16)) - 8;
                    7, 8:       cand = longint'($urandom_range(0, 40)) - 20;
                    default:    cand = longint'(spf_pkg::data_t'($urandom()));
                endcase
                if (cand < longint'(VAL_MIN) || cand > longint'(VAL_MAX))
                    cand = longint'(spf_pkg::data_t'($urandom()));
                v = spf_pkg::data_t'(cand);
                send_sample(v, (j == set_len - 1), 1'b0, '0);
                prev_v = v;
            end
        end

        if (sample_up)
        begin
            sample_ch.valid <= 1'b0;
            sample_up = 1'b0;
        end
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d values in %0d sets (%0d over capacity), %0d pairs matched.",
                 sample_count, set_count, overflow_sets, pair_count);
        $display("Mismatches recorded: %0d", bad_count);
        if (bad_count == 0)
            $display("sorted_pair_sum_finder_top verification clean");
        else
            $display("sorted_pair_sum_finder_top verification failed");
        $finish;
    end

    // result side: random stalls, compare each transfer with the oldest expectation
    initial begin
        pair_res_t want;
        int        hold;
        hold = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (pending_pairs.size() == 0)
                    report_mismatch($sformatf("unexpected result low %0d high %0d found %0b",
                                              result_ch.low_value, result_ch.high_value,
                                              result_ch.pair_found));
                else
                begin
                    want = pending_pairs.pop_front();
                    if (result_ch.low_value !== want.low_v)
                        report_mismatch($sformatf("low_value %0d, want %0d",
                                                  result_ch.low_value, want.low_v));
                    if (result_ch.high_value !== want.high_v)
                        report_mismatch($sformatf("high_value %0d, want %0d",
                                                  result_ch.high_value, want.high_v));
                    if (result_ch.pair_found !== want.found)
                        report_mismatch($sformatf("pair_found %0b, want %0b",
                                                  result_ch.pair_found, want.found));
                    if (result_ch.overflow !== want.ovf)
                        report_mismatch($sformatf("overflow %0b, want %0b",
                                                  result_ch.overflow, want.ovf));
                    if (result_ch.run_end !== want.fin)
                        report_mismatch($sformatf("run_end %0b, want %0b",
                                                  result_ch.run_end, want.fin));
                    if (want.found)
                        pair_count++;
                end
                if ($urandom_range(0, 29) == 0)
                    recv_calm = !recv_calm;
                hold = recv_calm ? 0 : $urandom_range(0, 14);
            end
            if (hold > 0)
            begin
                result_ch.ready <= 1'b0;
                hold--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("[%0t] timeout with %0d results outstanding", $time, pending_pairs.size());
        $display("sorted_pair_sum_finder_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
design/spf_pkg.sv
design/spf_sample_if.sv
design/spf_result_if.sv
design/spf_cell.sv
design/spf_chain.sv
design/sorted_pair_sum_finder_top.sv
bench/tb_top.sv
